### rtl/pli_pkg.sv
// Shared types and constants for the piecewise linear interpolator.
// Depends on nothing; used by every file of the block except pli_ram.
`timescale 1ns / 1ps

package pli_pkg;

   localparam int WL_W     = 16;   // unsigned Q10.6 wavelength
   localparam int VAL_W    = 24;   // signed Q8.16 value
   localparam int FRAC_W   = 16;   // fraction bits of t
   localparam int CNT_W    = 7;    // holds points_in_use and scan index
   localparam int IDX_W    = 6;    // entry_index width
   localparam int PDATA_W  = 32;
   localparam int PADDR_W  = 2;

   localparam logic [PADDR_W-1:0] CSR_POINTS_IN_USE = 2'd0;

   typedef enum logic [0:0] {
      OP_LOAD = 1'b0,
      OP_EVAL = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             table_write;
      logic             capture_query;
      logic             scan_read;
      logic [CNT_W-1:0] scan_addr;
      logic             div_init;
      logic             div_step;
      logic             sat_load;
      logic             mult;
      logic             result_load;
   } dp_cmd_type;

   typedef struct packed {
      logic ok;
      logic sat;
   } dp_status_type;

endpackage

### rtl/pli_req_if.sv
// Request channel of the interpolator: valid/ready plus one input word.
// Depends on pli_pkg.
`timescale 1ns / 1ps

interface pli_req_if;
   logic                                valid;
   logic                                ready;
   pli_pkg::opcode_type                 opcode;
   logic        [pli_pkg::IDX_W-1:0]    entry_index;
   logic        [pli_pkg::WL_W-1:0]     entry_wavelength;
   logic signed [pli_pkg::VAL_W-1:0]    entry_value;
   logic        [pli_pkg::WL_W-1:0]     query_wavelength;

   modport source (
      output valid, opcode, entry_index, entry_wavelength, entry_value, query_wavelength,
      input  ready
   );
   modport sink (
      input  valid, opcode, entry_index, entry_wavelength, entry_value, query_wavelength,
      output ready
   );
endinterface

### rtl/pli_rsp_if.sv
// Response channel of the interpolator: valid/ready plus one result word.
// Depends on pli_pkg.
`timescale 1ns / 1ps

interface pli_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [pli_pkg::VAL_W-1:0] result_value;
   logic                             in_range;

   modport source (
      output valid, result_value, in_range,
      input  ready
   );
   modport sink (
      input  valid, result_value, in_range,
      output ready
   );
endinterface

### rtl/pli_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pli_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [AW-1:0]            rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/pli_datapath.sv
// Datapath: breakpoint table, scan capture, bit-serial divider, multiplier
// and result register. Depends on pli_pkg and pli_ram.
`timescale 1ns / 1ps

module pli_datapath #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pli_pkg::dp_cmd_type                 cmd,
   input  logic        [pli_pkg::CNT_W-1:0]    n,
   input  logic        [pli_pkg::IDX_W-1:0]    entry_index,
   input  logic        [pli_pkg::WL_W-1:0]     entry_wavelength,
   input  logic signed [pli_pkg::VAL_W-1:0]    entry_value,
   input  logic        [pli_pkg::WL_W-1:0]     query_wavelength,
   output pli_pkg::dp_status_type              status,
   output logic signed [pli_pkg::VAL_W-1:0]    result_value,
   output logic                                in_range
);
   localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int WL_W   = pli_pkg::WL_W;
   localparam int VAL_W  = pli_pkg::VAL_W;
   localparam int FRAC_W = pli_pkg::FRAC_W;
   localparam int CNT_W  = pli_pkg::CNT_W;
   localparam int ENT_W  = WL_W + VAL_W;
   localparam int PROD_W = FRAC_W + VAL_W + 2;   // t * (b - a), signed

   logic                    wr_en;
   logic [ENT_W-1:0]        rd_data;
   logic [WL_W-1:0]         rd_wl;
   logic [VAL_W-1:0]        rd_val;
   logic                    sel;

   logic                    rd_valid_ff;
   logic [CNT_W-1:0]        rd_idx_ff;
   logic                    sel_prev_ff;
   logic [WL_W-1:0]         query_ff;
   logic [WL_W-1:0]         wl0_ff;
   logic [WL_W-1:0]         wlast_ff;
   logic [WL_W-1:0]         lo_wl_ff;
   logic [WL_W-1:0]         hi_wl_ff;
   logic [VAL_W-1:0]        lo_val_ff;
   logic [VAL_W-1:0]        hi_val_ff;
   logic [WL_W-1:0]         rem_ff;
   logic [FRAC_W:0]         quo_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [VAL_W-1:0] result_ff;
   logic                    in_range_ff;

   logic [WL_W-1:0]         num;
   logic [WL_W-1:0]         den;
   logic [WL_W:0]           shifted;
   logic [WL_W:0]           shifted_sub;
   logic                    ge;
   logic signed [VAL_W:0]   val_diff;
   logic signed [FRAC_W+1:0] t_s;
   logic signed [FRAC_W+VAL_W+2:0] prod_full;
   logic signed [PROD_W-1:0] sum;

   // loads beyond the table are dropped
   assign wr_en = cmd.table_write && (32'(entry_index) < TABLE_DEPTH);

   pli_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(entry_index)),
      .wr_data ({entry_wavelength, entry_value}),
      .rd_addr (AW'(cmd.scan_addr)),
      .rd_data (rd_data)
   );

   assign rd_wl  = rd_data[ENT_W-1:VAL_W];
   assign rd_val = rd_data[VAL_W-1:0];

   // candidate lower point: index within 0..n-2 and wavelength <= query
   assign sel = rd_valid_ff
             && (({1'b0, rd_idx_ff} + (CNT_W+1)'(2)) <= {1'b0, n})
             && (rd_wl <= query_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         sel_prev_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.scan_read;
         if (cmd.capture_query) begin
            sel_prev_ff <= 1'b0;
         end else if (rd_valid_ff) begin
            sel_prev_ff <= sel;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= cmd.scan_addr;
      if (cmd.capture_query) begin
         query_ff <= query_wavelength;
      end
      if (rd_valid_ff) begin
         if (rd_idx_ff == '0) begin
            wl0_ff <= rd_wl;
         end
         if (rd_idx_ff == CNT_W'(n - CNT_W'(1))) begin
            wlast_ff <= rd_wl;
         end
         if (sel_prev_ff) begin
            hi_wl_ff  <= rd_wl;
            hi_val_ff <= rd_val;
         end
         if (sel) begin
            lo_wl_ff  <= rd_wl;
            lo_val_ff <= rd_val;
         end
      end
   end

   assign num = query_ff - lo_wl_ff;
   assign den = hi_wl_ff - lo_wl_ff;

   assign status.ok = (n >= CNT_W'(2)) && (query_ff >= wl0_ff) && (query_ff <= wlast_ff)
                   && (hi_wl_ff > lo_wl_ff);
   assign status.sat = (num >= den);

   // restoring division, one quotient bit per step; remainder stays below den
   assign shifted     = {rem_ff, 1'b0};
   assign shifted_sub = shifted - {1'b0, den};
   assign ge          = (shifted >= {1'b0, den});

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff <= num;
         quo_ff <= '0;
      end else if (cmd.sat_load) begin
         quo_ff <= (FRAC_W+1)'(1) << FRAC_W;
      end else if (cmd.div_step) begin
         rem_ff <= ge ? shifted_sub[WL_W-1:0] : shifted[WL_W-1:0];
         quo_ff <= {quo_ff[FRAC_W-1:0], ge};
      end
   end

   // value = a + t*(b - a) / 2^16, floored
   assign val_diff  = $signed({hi_val_ff[VAL_W-1], hi_val_ff})
                    - $signed({lo_val_ff[VAL_W-1], lo_val_ff});
   assign t_s       = $signed({1'b0, quo_ff});
   assign prod_full = t_s * val_diff;
   assign sum       = $signed({{2{lo_val_ff[VAL_W-1]}}, lo_val_ff, {FRAC_W{1'b0}}}) + prod_ff;

   always_ff @(posedge clock) begin
      if (cmd.mult) begin
         prod_ff <= prod_full[PROD_W-1:0];
      end
      if (cmd.result_load) begin
         result_ff   <= status.ok ? sum[FRAC_W+VAL_W-1:FRAC_W] : '0;
         in_range_ff <= status.ok;
      end
   end

   assign result_value = result_ff;
   assign in_range     = in_range_ff;
endmodule

### rtl/pli_controller.sv
// Controller: sequences table scan, division, multiply and result hand-off.
// Depends on pli_pkg.
`timescale 1ns / 1ps

module pli_controller (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  pli_pkg::opcode_type           req_opcode,
   output logic                          req_ready,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   input  logic [pli_pkg::CNT_W-1:0]     n,
   input  pli_pkg::dp_status_type        status,
   output pli_pkg::dp_cmd_type           cmd
);
   localparam int CNT_W = pli_pkg::CNT_W;

   pli_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               req_fire;
   logic               out_free;

   assign req_ready = (state_ff == pli_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // next state and counter
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         pli_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (req_fire && req_opcode == pli_pkg::OP_EVAL) begin
               state_in = pli_pkg::ST_SCAN;
            end
         end
         pli_pkg::ST_SCAN: begin
            if (cnt_ff == n) begin
               state_in = pli_pkg::ST_CHECK;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         pli_pkg::ST_CHECK: begin
            cnt_in = '0;
            if (!status.ok) begin
               state_in = pli_pkg::ST_FINISH;
            end else if (status.sat) begin
               state_in = pli_pkg::ST_MULTIPLY;
            end else begin
               state_in = pli_pkg::ST_DIVIDE;
            end
         end
         pli_pkg::ST_DIVIDE: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(pli_pkg::FRAC_W - 1)) begin
               state_in = pli_pkg::ST_MULTIPLY;
            end
         end
         pli_pkg::ST_MULTIPLY: begin
            state_in = pli_pkg::ST_FINISH;
         end
         pli_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = pli_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pli_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath commands
   always_comb begin
      cmd = '0;
      cmd.scan_addr = cnt_ff;
      case (state_ff)
         pli_pkg::ST_IDLE: begin
            cmd.table_write   = req_fire && (req_opcode == pli_pkg::OP_LOAD);
            cmd.capture_query = req_fire && (req_opcode == pli_pkg::OP_EVAL);
         end
         pli_pkg::ST_SCAN: begin
            cmd.scan_read = (cnt_ff != n);
         end
         pli_pkg::ST_CHECK: begin
            cmd.div_init = status.ok && !status.sat;
            cmd.sat_load = status.ok && status.sat;
         end
         pli_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         pli_pkg::ST_MULTIPLY: begin
            cmd.mult = 1'b1;
         end
         pli_pkg::ST_FINISH: begin
            cmd.result_load = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || cmd.result_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pli_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

### rtl/piecewise_linear_interpolator_core.sv
// Piecewise linear interpolator, top level.
// Depends on pli_pkg, pli_req_if, pli_rsp_if, pli_controller, pli_datapath.
//
// Usage:
//  - req_ch carries one word per item. opcode LOAD writes entry_index with a
//    wavelength/value pair (indices at or beyond TABLE_DEPTH are dropped) and
//    gives no response. opcode EVAL gives exactly one rsp_ch word.
//  - points_in_use (APB, address 0) sets how many entries are live; values
//    above TABLE_DEPTH act as TABLE_DEPTH. Write it only while idle.
//  - Loads can stream back to back.
//  - An evaluate scans the table through the single RAM read port, then
//    runs a check step, bit-serial division, one multiply and one output
//    step. Out-of-range queries skip divide and multiply; a query at the
//    upper point of its segment skips only the divide.
//  - req_ch.ready is high only between evaluations.
//  - The result sits in an output register; a stalled rsp_ch holds it while
//    the next item is taken. A following result waits in its final step.
//  - Synchronous reset clears control and points_in_use; table contents are
//    undefined until loaded.
`timescale 1ns / 1ps

module piecewise_linear_interpolator_core #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   pli_req_if.sink                         req_ch,
   pli_rsp_if.source                       rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [pli_pkg::PADDR_W-1:0]     paddr,
   input  logic [pli_pkg::PDATA_W-1:0]     pwdata,
   output logic [pli_pkg::PDATA_W-1:0]     prdata,
   output logic                            pready
);
   localparam int CNT_W = pli_pkg::CNT_W;

   logic [CNT_W-1:0]          points_ff;
   logic [CNT_W-1:0]          n_eff;
   logic                      csr_write;
   pli_pkg::dp_cmd_type       cmd;
   pli_pkg::dp_status_type    status;

   // config port: zero-wait, one register
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                   && (paddr == pli_pkg::CSR_POINTS_IN_USE);
   assign prdata    = (paddr == pli_pkg::CSR_POINTS_IN_USE)
                    ? pli_pkg::PDATA_W'(points_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= '0;
      end else if (csr_write) begin
         points_ff <= pwdata[CNT_W-1:0];
      end
   end

   // count clamped to the table size
   assign n_eff = (32'(points_ff) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : points_ff;

   pli_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_opcode (req_ch.opcode),
      .req_ready  (req_ch.ready),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .n          (n_eff),
      .status     (status),
      .cmd        (cmd)
   );

   pli_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .n                (n_eff),
      .entry_index      (req_ch.entry_index),
      .entry_wavelength (req_ch.entry_wavelength),
      .entry_value      (req_ch.entry_value),
      .query_wavelength (req_ch.query_wavelength),
      .status           (status),
      .result_value     (rsp_ch.result_value),
      .in_range         (rsp_ch.in_range)
   );
endmodule

### rtl/pli_checker.sv
// Port-level checks for the interpolator, bound to the top level.
// Depends on pli_pkg and piecewise_linear_interpolator_core.
`timescale 1ns / 1ps

module pli_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input pli_pkg::opcode_type              req_opcode,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic signed [pli_pkg::VAL_W-1:0] result_value,
   input logic                             in_range
);
   logic eval_fire;

   assign eval_fire = req_valid && req_ready && (req_opcode == pli_pkg::OP_EVAL);

   // no stale word survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_value) && $stable(in_range))
      else $error("stalled response changed");

   // out of range always reads as zero
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !in_range |-> result_value == '0)
      else $error("out-of-range response not zero");

   // an evaluate blocks input and cannot answer in the next cycle
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      eval_fire |=> !req_ready && !$rose(rsp_valid))
      else $error("evaluate finished too early");
endmodule

bind piecewise_linear_interpolator_core pli_checker u_pli_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .req_opcode   (req_ch.opcode),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .result_value (rsp_ch.result_value),
   .in_range     (rsp_ch.in_range)
);

### verif/testbench.sv
// Self-checking bench for piecewise_linear_interpolator_core: drives load and
// evaluate words, predicts every result from its own copy of the breakpoints.
// Depends on pli_pkg, pli_req_if, pli_rsp_if and the core RTL.
`timescale 1ns / 1ps

module testbench;
   localparam int IDX_W   = pli_pkg::IDX_W;
   localparam int WL_W    = pli_pkg::WL_W;
   localparam int VAL_W   = pli_pkg::VAL_W;
   localparam int FRAC_W  = pli_pkg::FRAC_W;
   localparam int CNT_W   = pli_pkg::CNT_W;
   localparam int PADDR_W = pli_pkg::PADDR_W;
   localparam int PDATA_W = pli_pkg::PDATA_W;

   localparam int TABLE_DEPTH    = 64;
   localparam int DRAIN_CYCLES   = 100;   // margin for the longest evaluate
   localparam int WATCHDOG_LIMIT = 5000;  // cycles with no word moving
   localparam longint UNITY_Q16  = 64'sd1 << FRAC_W;

   // one request word as the bench sees it
   typedef struct {
      pli_pkg::opcode_type    opcode;
      logic [IDX_W-1:0]       index;
      logic [WL_W-1:0]        wavelength;
      logic signed [VAL_W-1:0] value;
      logic [WL_W-1:0]        query;
   } table_op_type;

   // one response word
   typedef struct {
      logic signed [VAL_W-1:0] value;
      logic                    in_range;
   } sample_type;

   logic                clock;
   logic                reset;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [PADDR_W-1:0]  paddr;
   logic [PDATA_W-1:0]  pwdata;
   logic [PDATA_W-1:0]  prdata;
   logic                pready;

   pli_req_if req_ch ();
   pli_rsp_if rsp_ch ();

   piecewise_linear_interpolator_core #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // bench copy of the block state
   logic [WL_W-1:0]         wl_table    [TABLE_DEPTH];
   logic signed [VAL_W-1:0] value_table [TABLE_DEPTH];
   logic [CNT_W-1:0]        live_points = '0;

   sample_type  pending_samples[$];   // expected results, oldest first
   int unsigned error_count = 0;
   int unsigned words_sent  = 0;
   int unsigned idle_pct    = 0;      // sender idle odds per cycle, percent
   int unsigned stall_pct   = 0;      // receiver stall odds per cycle, percent
   int unsigned quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor: value at query wavelength q for the current table.
   // ------------------------------------------------------------------
   function automatic sample_type interpolate_at(input logic [WL_W-1:0] q);
      sample_type  r;
      int unsigned n;
      int unsigned lower;
      longint      span;
      longint      offset;
      longint      frac;
      longint      weighted;
      r.value    = '0;
      r.in_range = 1'b0;
      n = (live_points > TABLE_DEPTH) ? TABLE_DEPTH : live_points;
      // fewer than two points, or query off either end of the span
      if (n < 2) return r;
      if (q < wl_table[0] || q > wl_table[n-1]) return r;
      // last segment start at or below q, limited to n-2
      lower = 0;
      for (int i = 0; i + 2 <= n; i++)
         if (wl_table[i] <= q) lower = i;
      // flat or falling segment gives zero
      if (wl_table[lower+1] <= wl_table[lower]) return r;
      span   = longint'(wl_table[lower+1]) - longint'(wl_table[lower]);
      offset = longint'(q) - longint'(wl_table[lower]);
      frac   = (offset << FRAC_W) / span;          // Q1.16, truncated
      if (frac > UNITY_Q16) frac = UNITY_Q16;
      weighted = (UNITY_Q16 - frac) * longint'(value_table[lower])
               + frac * longint'(value_table[lower+1]);
      r.value    = VAL_W'(weighted >>> FRAC_W);    // one floor over the sum
      r.in_range = 1'b1;
      return r;
   endfunction

   function automatic logic signed [VAL_W-1:0] random_value();
      case ($urandom_range(9))
         0: return {1'b1, {(VAL_W-1){1'b0}}};
         1: return {1'b0, {(VAL_W-1){1'b1}}};
         default: return VAL_W'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Request side: one word per call, random idle beforehand.
   // State update happens at the accepting edge, so the predictor sees
   // words in exactly the order the block does.
   // ------------------------------------------------------------------
   task automatic issue_word(input table_op_type w);
      int unsigned gap;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
      @(negedge clock);
      if (gap != 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.opcode           = w.opcode;
      req_ch.entry_index      = w.index;
      req_ch.entry_wavelength = w.wavelength;
      req_ch.entry_value      = w.value;
      req_ch.query_wavelength = w.query;
      req_ch.valid            = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
      if (w.opcode == pli_pkg::OP_LOAD) begin
         wl_table[w.index]    = w.wavelength;
         value_table[w.index] = w.value;
      end else begin
         pending_samples = {pending_samples, interpolate_at(w.query)};
      end
   endtask

   task automatic load_entry(input int unsigned idx, input logic [WL_W-1:0] wl,
                             input logic signed [VAL_W-1:0] val);
      table_op_type w;
      w.opcode     = pli_pkg::OP_LOAD;
      w.index      = IDX_W'(idx);
      w.wavelength = wl;
      w.value      = val;
      w.query      = WL_W'($urandom);     // ignored by a load
      issue_word(w);
   endtask

   task automatic eval_at(input logic [WL_W-1:0] q);
      table_op_type w;
      w.opcode     = pli_pkg::OP_EVAL;
      w.index      = IDX_W'($urandom);    // entry fields ignored here
      w.wavelength = WL_W'($urandom);
      w.value      = VAL_W'($urandom);
      w.query      = q;
      issue_word(w);
   endtask

   // Drop valid, let every result come back, then cover a trailing load.
   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // APB write of points_in_use, only once the block has gone quiet
   task automatic set_point_count(input int unsigned count);
      wait_idle();
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = pli_pkg::CSR_POINTS_IN_USE;
      pwdata  = PDATA_W'(count);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      live_points = CNT_W'(count);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // Fill entries 0..eff-1. Mostly strictly rising; sometimes fine steps,
   // sometimes scrambled wavelengths, sometimes an equal last pair.
   task automatic load_random_breakpoints(input int unsigned eff);
      logic [WL_W-1:0] plan [TABLE_DEPTH];
      int unsigned     start;
      int unsigned     room;
      int unsigned     shape;
      int unsigned     idx;
      bit              descending;
      shape = $urandom_range(7);
      start = $urandom_range(0, 65535 - (eff - 1));
      if ($urandom_range(9) == 0) start = 0;
      room = (65535 - start) / (eff - 1);
      if (shape == 1 && room > 3) room = 3;
      plan[0] = WL_W'(start);
      for (int i = 1; i < eff; i++)
         plan[i] = WL_W'(plan[i-1] + $urandom_range(1, room));
      if (shape == 6)
         for (int i = 0; i < eff; i++) plan[i] = WL_W'($urandom);
      if (shape == 7) plan[eff-1] = plan[eff-2];
      descending = ($urandom_range(2) == 0);
      for (int j = 0; j < eff; j++) begin
         idx = descending ? eff - 1 - j : j;
         load_entry(idx, plan[idx], random_value());
      end
   endtask

   // One random word against a table of eff live points
   task automatic send_random_query(input int unsigned eff);
      logic [WL_W-1:0] lo_q;
      logic [WL_W-1:0] hi_q;
      logic [WL_W-1:0] q;
      int unsigned     sel;
      int unsigned     idx;
      if (eff < 2) begin
         eval_at(WL_W'($urandom));
         return;
      end
      lo_q = wl_table[0];
      hi_q = wl_table[eff-1];
      sel  = $urandom_range(99);
      if (sel < 55) begin
         q = WL_W'($urandom_range(lo_q, hi_q));
      end else if (sel < 70) begin
         q = wl_table[$urandom_range(0, eff - 1)];
      end else if (sel < 80) begin
         // just past one end of the span
         q = ($urandom_range(1) == 1 && lo_q != 0) ? lo_q - 1'b1 : hi_q + 1'b1;
      end else if (sel < 92) begin
         q = WL_W'($urandom);
      end else if (sel < 97) begin
         // rewrite one live value in place, between evaluations
         idx = $urandom_range(0, eff - 1);
         load_entry(idx, wl_table[idx], random_value());
         return;
      end else begin
         load_entry($urandom_range(0, TABLE_DEPTH - 1), WL_W'($urandom), random_value());
         return;
      end
      eval_at(q);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // count 0 and 1: every query is out of range
   task automatic test_empty_table();
      set_point_count(0);
      eval_at(16'h0000);
      eval_at(16'hFFFF);
      set_point_count(1);
      load_entry(0, 16'h0000, 24'sh7FFFFF);
      eval_at(16'h0000);
   endtask

   // full-scale wavelengths and values, exact breakpoints, floor of -0.5
   task automatic test_extreme_points();
      load_entry(0, 16'h0000, 24'sh800000);
      load_entry(1, 16'h0040, 24'sh7FFFFF);
      load_entry(2, 16'h8000, 24'sh000000);
      load_entry(3, 16'hFFFF, 24'shFFFFFF);
      set_point_count(4);
      eval_at(16'h0000);
      eval_at(16'h0020);
      eval_at(16'h0040);
      eval_at(16'h4000);
      eval_at(16'hFFFE);
      eval_at(16'hFFFF);
      // two-point table: just above and just inside
      set_point_count(2);
      eval_at(16'h0041);
      eval_at(16'h0001);
   endtask

   // below/above the span, mid segments, then a flat last pair
   task automatic test_span_edges();
      load_entry(0, 16'h1000, 24'sh010000);
      load_entry(1, 16'h2000, 24'sh020000);
      load_entry(2, 16'h3000, -24'sh010000);
      set_point_count(3);
      eval_at(16'h0FFF);
      eval_at(16'h3001);
      eval_at(16'h1800);
      eval_at(16'h2800);
      load_entry(2, 16'h2000, 24'sh055555);
      eval_at(16'h2000);
   endtask

   // deepest table, then counts above the depth that must clamp
   task automatic test_full_table();
      idle_pct  = 0;
      stall_pct = 0;
      set_point_count(TABLE_DEPTH);
      load_random_breakpoints(TABLE_DEPTH);
      repeat (6) send_random_query(TABLE_DEPTH);
      set_point_count(127);
      repeat (6) send_random_query(TABLE_DEPTH);
      set_point_count(100);
      repeat (4) send_random_query(TABLE_DEPTH);
   endtask

   // phases of: pick a count, load a table, run a burst of queries
   task automatic test_random_traffic(input int unsigned budget, input int unsigned idle,
                                      input int unsigned stall);
      int unsigned stop_at;
      int unsigned count;
      int unsigned eff;
      int unsigned pick;
      stop_at   = words_sent + budget;
      idle_pct  = idle;
      stall_pct = stall;
      while (words_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 5)       count = $urandom_range(0, 1);
         else if (pick < 75) count = $urandom_range(2, 8);
         else if (pick < 90) count = $urandom_range(9, TABLE_DEPTH - 1);
         else if (pick < 96) count = TABLE_DEPTH;
         else                count = $urandom_range(TABLE_DEPTH + 1, 127);
         set_point_count(count);
         eff = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
         if (eff >= 2) load_random_breakpoints(eff);
         repeat ($urandom_range(3, 24)) send_random_query(eff);
      end
   endtask

   // ------------------------------------------------------------------
   // Response side: random backpressure, check at the accepting edge
   // ------------------------------------------------------------------
   always @(negedge clock)
      rsp_ch.ready = ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin : check_samples
      sample_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_samples.size() == 0) begin
            $display("%0t: unexpected result word, value %0d in_range %0b",
                     $time, rsp_ch.result_value, rsp_ch.in_range);
            error_count++;
         end else begin
            want = pending_samples.pop_front();
            if (rsp_ch.result_value !== want.value) begin
               $display("%0t: result_value mismatch, expected %0d, got %0d",
                        $time, want.value, rsp_ch.result_value);
               error_count++;
            end
            if (rsp_ch.in_range !== want.in_range) begin
               $display("%0t: in_range mismatch, expected %0b, got %0b",
                        $time, want.in_range, rsp_ch.in_range);
               error_count++;
            end
         end
      end
   end

   // ends the run if no word moves on either channel for too long
   initial begin : watchdog
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin : run
      reset                   = 1'b1;
      psel                    = 1'b0;
      penable                 = 1'b0;
      pwrite                  = 1'b0;
      paddr                   = '0;
      pwdata                  = '0;
      req_ch.valid            = 1'b0;
      req_ch.opcode           = pli_pkg::OP_LOAD;
      req_ch.entry_index      = '0;
      req_ch.entry_wavelength = '0;
      req_ch.entry_value      = '0;
      req_ch.query_wavelength = '0;
      rsp_ch.ready            = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_table();
      test_extreme_points();
      test_span_edges();
      test_full_table();
      test_random_traffic(450, 0, 0);
      test_random_traffic(450, 53, 0);
      test_random_traffic(450, 0, 53);
      test_random_traffic(400, 37, 37);

      wait_idle();
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

### sim.f
rtl/pli_pkg.sv
rtl/pli_req_if.sv
rtl/pli_rsp_if.sv
rtl/pli_ram.sv
rtl/pli_datapath.sv
rtl/pli_controller.sv
rtl/piecewise_linear_interpolator_core.sv
rtl/pli_checker.sv
verif/testbench.sv
